[design/three_axis_field_filter_assert.svh]
// Assertion macros shared by the field filter RTL.
// Uses the clk and rst_n names of the including module; no other dependencies.
`ifndef THREE_AXIS_FIELD_FILTER_ASSERT_SVH
`define THREE_AXIS_FIELD_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define TAFF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TAFF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define TAFF_ASSERT(lbl, prop, msg)
`define TAFF_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[design/taff_pkg.sv]
// Shared types and constants of the three-axis field filter.
// Used by the lane, the divider and the top level; depends on nothing.
package taff_pkg;

  localparam int RAW_W   = 16;
  localparam int FIELD_W = 32;
  localparam int AVG_W   = 40;
  localparam int DIV_W   = 41;
  localparam int PROD_W  = 51;
  localparam int AXES    = 3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_DATA  = 2'd1;
  localparam logic [1:0] ST_BUS_FAIL = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_AVG   = 2'd1;
  localparam logic [1:0] MODE_EXP   = 2'd2;

  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_WINDOW = 2'd1;
  localparam logic [1:0] CFG_RES    = 2'd2;
  localparam logic [1:0] CFG_WEIGHT = 2'd3;

  localparam logic [7:0]  WIN_RESET    = 8'd10;
  localparam logic [15:0] RES_RESET    = 16'd9830;
  localparam logic [15:0] WEIGHT_RESET = 16'd6554;

  localparam logic [2:0] OP_PLAIN   = 3'd0;
  localparam logic [2:0] OP_FILL    = 3'd1;
  localparam logic [2:0] OP_CONVERT = 3'd2;
  localparam logic [2:0] OP_RECUR   = 3'd3;
  localparam logic [2:0] OP_SMOOTH  = 3'd4;

  typedef struct packed {
    logic        start;
    logic        clear;
    logic [2:0]  op;
    logic [7:0]  divc;
    logic [7:0]  win;
    logic [15:0] weight;
    logic [15:0] res;
  } lane_ctl_t;

endpackage

[design/taff_div.sv]
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
// Depends on taff_pkg for the dividend width.
module taff_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [taff_pkg::DIV_W-1:0] dividend,
  input  logic [7:0]                       divisor,
  output logic                             done,
  output logic signed [taff_pkg::DIV_W-1:0] quotient
);

  localparam logic [5:0] STEPS = 6'(taff_pkg::DIV_W);

  logic                       busy_r;
  logic                       done_r;
  logic [5:0]                 cnt_r;
  logic [taff_pkg::DIV_W-1:0] ab_r;
  logic [7:0]                 rem_r;
  logic [7:0]                 dvs_r;
  logic                       neg_r;
  logic [8:0]                 shifted;
  logic                       ge;
  logic [8:0]                 diff;

  assign shifted = {rem_r, ab_r[taff_pkg::DIV_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[taff_pkg::DIV_W-1];
      ab_r  <= dividend[taff_pkg::DIV_W-1] ? -dividend : dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[7:0] : shifted[7:0];
      ab_r  <= {ab_r[taff_pkg::DIV_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(ab_r) : $signed(ab_r);

endmodule

[design/taff_lane.sv]
// One axis lane: scaling multiplier, averaging and smoothing state, and its own divider.
// Depends on taff_pkg and instantiates taff_div.
module taff_lane (
  input  logic                               clk,
  input  logic                               rst_n,
  input  taff_pkg::lane_ctl_t                ctl,
  input  logic signed [taff_pkg::RAW_W-1:0]  raw,
  output logic                               done,
  output logic signed [taff_pkg::FIELD_W-1:0] result
);

  localparam logic [3:0] L_IDLE   = 4'd0;
  localparam logic [3:0] L_MUL    = 4'd1;
  localparam logic [3:0] L_ADD    = 4'd2;
  localparam logic [3:0] L_FSTART = 4'd3;
  localparam logic [3:0] L_FDIV   = 4'd4;
  localparam logic [3:0] L_CSTART = 4'd5;
  localparam logic [3:0] L_CDIV   = 4'd6;
  localparam logic [3:0] L_RMUL   = 4'd7;
  localparam logic [3:0] L_RSTART = 4'd8;
  localparam logic [3:0] L_RDIV   = 4'd9;
  localparam logic [3:0] L_SMUL1  = 4'd10;
  localparam logic [3:0] L_SMUL2  = 4'd11;
  localparam logic [3:0] L_SSUM   = 4'd12;
  localparam logic [3:0] L_DONE   = 4'd13;

  logic [3:0]                         state_r, state_nxt;
  logic [2:0]                         op_r;
  logic [7:0]                         divc_r;
  logic signed [taff_pkg::RAW_W-1:0]  raw_r;
  logic signed [taff_pkg::FIELD_W-1:0] scaled_r;
  logic signed [taff_pkg::AVG_W-1:0]  avg_r;
  logic signed [taff_pkg::FIELD_W-1:0] smooth_r;
  logic signed [taff_pkg::FIELD_W-1:0] result_r;
  logic signed [taff_pkg::DIV_W-1:0]  prod_r;
  logic signed [taff_pkg::PROD_W-1:0] p1_r;
  logic signed [taff_pkg::PROD_W-1:0] p2_r;

  logic signed [32:0]                 scale_full;
  logic signed [taff_pkg::DIV_W-1:0]  rprod;
  logic [16:0]                        wcomp;
  logic signed [taff_pkg::PROD_W-1:0] wprod;
  logic signed [taff_pkg::PROD_W-1:0] cprod;
  logic signed [taff_pkg::PROD_W-1:0] ssum;
  logic signed [taff_pkg::PROD_W-1:0] sshift;
  logic signed [taff_pkg::FIELD_W-1:0] snew;
  logic                               div_start;
  logic signed [taff_pkg::DIV_W-1:0]  div_dividend;
  logic [7:0]                         div_divisor;
  logic                               div_done;
  logic signed [taff_pkg::DIV_W-1:0]  div_q;

  assign scale_full = $signed(raw_r) * $signed({1'b0, ctl.res});
  assign rprod      = $signed(avg_r[taff_pkg::FIELD_W-1:0]) * $signed({1'b0, ctl.win - 8'd1});
  assign wcomp      = 17'h10000 - {1'b0, ctl.weight};
  assign wprod      = $signed({1'b0, ctl.weight}) * scaled_r;
  assign cprod      = $signed({1'b0, wcomp}) * smooth_r;
  assign ssum       = p1_r + p2_r;
  assign sshift     = ssum >>> 16;
  assign snew       = sshift[taff_pkg::FIELD_W-1:0]
                      + ((ssum[taff_pkg::PROD_W-1] && (ssum[15:0] != 16'd0)) ? 32'sd1 : 32'sd0);

  assign div_start    = (state_r == L_FSTART) || (state_r == L_CSTART) || (state_r == L_RSTART);
  assign div_dividend = (state_r == L_RSTART)
                        ? prod_r + {{(taff_pkg::DIV_W-taff_pkg::FIELD_W){scaled_r[31]}}, scaled_r}
                        : {avg_r[taff_pkg::AVG_W-1], avg_r};
  assign div_divisor  = (state_r == L_RSTART) ? ctl.win : divc_r;

  taff_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      L_IDLE:   if (ctl.start) state_nxt = L_MUL;
      L_MUL: begin
        case (op_r)
          taff_pkg::OP_FILL:    state_nxt = L_ADD;
          taff_pkg::OP_CONVERT: state_nxt = L_CSTART;
          taff_pkg::OP_RECUR:   state_nxt = L_RMUL;
          taff_pkg::OP_SMOOTH:  state_nxt = L_SMUL1;
          default:              state_nxt = L_DONE;
        endcase
      end
      L_ADD:    state_nxt = L_FSTART;
      L_FSTART: state_nxt = L_FDIV;
      L_FDIV:   if (div_done) state_nxt = L_DONE;
      L_CSTART: state_nxt = L_CDIV;
      L_CDIV:   if (div_done) state_nxt = L_RMUL;
      L_RMUL:   state_nxt = L_RSTART;
      L_RSTART: state_nxt = L_RDIV;
      L_RDIV:   if (div_done) state_nxt = L_DONE;
      L_SMUL1:  state_nxt = L_SMUL2;
      L_SMUL2:  state_nxt = L_SSUM;
      L_SSUM:   state_nxt = L_DONE;
      L_DONE:   state_nxt = L_IDLE;
      default:  state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= L_IDLE;
      avg_r    <= '0;
      smooth_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (ctl.clear) begin
        avg_r <= '0;
      end else if (state_r == L_ADD) begin
        avg_r <= avg_r + {{(taff_pkg::AVG_W-taff_pkg::FIELD_W){scaled_r[31]}}, scaled_r};
      end else if (((state_r == L_CDIV) || (state_r == L_RDIV)) && div_done) begin
        avg_r <= div_q[taff_pkg::AVG_W-1:0];
      end
      if (state_r == L_SSUM) begin
        smooth_r <= snew;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == L_IDLE) && ctl.start) begin
      op_r   <= ctl.op;
      divc_r <= ctl.divc;
      raw_r  <= raw;
    end
    case (state_r)
      L_MUL: begin
        scaled_r <= scale_full[taff_pkg::FIELD_W-1:0];
        result_r <= scale_full[taff_pkg::FIELD_W-1:0];
      end
      L_FDIV, L_RDIV: if (div_done) result_r <= div_q[taff_pkg::FIELD_W-1:0];
      L_RMUL:  prod_r <= rprod;
      L_SMUL1: p1_r <= wprod;
      L_SMUL2: p2_r <= cprod;
      L_SSUM:  result_r <= snew;
      default: ;
    endcase
  end

  assign done   = (state_r == L_DONE);
  assign result = result_r;

endmodule

[design/three_axis_field_filter.sv]
// Three-axis magnetometer filter: status decode, Q15.16 scaling and plain, averaging or
// exponential smoothing of each axis in three parallel lanes; a word holds one sample. Each
// averaging word runs the 41-step radix-2 divider in each lane, and the one word where the
// window fills and the sum becomes a mean runs it twice. A word with an error status skips the
// lanes. A result that waits on out_ready holds off the next word for as long as it waits.
// Depends on taff_pkg, taff_lane and three_axis_field_filter_assert.svh.
`include "three_axis_field_filter_assert.svh"

module three_axis_field_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_data_ready,
  input  logic                                in_bus_ok,
  input  logic                                in_overflow,
  input  logic signed [taff_pkg::RAW_W-1:0]   in_raw_x,
  input  logic signed [taff_pkg::RAW_W-1:0]   in_raw_y,
  input  logic signed [taff_pkg::RAW_W-1:0]   in_raw_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic signed [taff_pkg::FIELD_W-1:0] out_field_x,
  output logic signed [taff_pkg::FIELD_W-1:0] out_field_y,
  output logic signed [taff_pkg::FIELD_W-1:0] out_field_z,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [15:0]                         cfg_wdata
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_BUSY = 2'd1;
  localparam logic [1:0] T_OUT  = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  mode_r;
  logic [7:0]  win_r;
  logic [15:0] res_r;
  logic [15:0] weight_r;
  logic [7:0]  count_r;
  logic        full_r;
  logic [1:0]  status_r;
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic signed [taff_pkg::FIELD_W-1:0] out_x_r, out_y_r, out_z_r;

  logic        accept;
  logic [1:0]  in_status;
  logic        in_err;
  logic [2:0]  op;
  logic [7:0]  divc;
  logic        out_load;
  taff_pkg::lane_ctl_t ctl;
  logic [taff_pkg::AXES-1:0] lane_done;
  logic signed [taff_pkg::RAW_W-1:0]   lane_raw [taff_pkg::AXES];
  logic signed [taff_pkg::FIELD_W-1:0] lane_res [taff_pkg::AXES];

  assign in_ready = (state_r == T_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state_r == T_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    if (!in_data_ready) begin
      in_status = taff_pkg::ST_NO_DATA;
    end else if (!in_bus_ok) begin
      in_status = taff_pkg::ST_BUS_FAIL;
    end else if (in_overflow) begin
      in_status = taff_pkg::ST_OVERFLOW;
    end else begin
      in_status = taff_pkg::ST_OK;
    end
  end

  assign in_err = (in_status != taff_pkg::ST_OK);

  always_comb begin
    op   = taff_pkg::OP_PLAIN;
    divc = count_r;
    case (mode_r)
      taff_pkg::MODE_AVG: begin
        if (!full_r && (count_r < win_r)) begin
          op   = taff_pkg::OP_FILL;
          divc = count_r + 8'd1;
        end else if (!full_r) begin
          op = taff_pkg::OP_CONVERT;
        end else begin
          op = taff_pkg::OP_RECUR;
        end
      end
      taff_pkg::MODE_EXP: op = taff_pkg::OP_SMOOTH;
      default:            op = taff_pkg::OP_PLAIN;
    endcase
  end

  always_comb begin
    ctl.start  = accept && !in_err;
    ctl.clear  = cfg_we && (cfg_index == taff_pkg::CFG_MODE);
    ctl.op     = op;
    ctl.divc   = divc;
    ctl.win    = win_r;
    ctl.weight = weight_r;
    ctl.res    = res_r;
  end

  assign lane_raw[0] = in_raw_x;
  assign lane_raw[1] = in_raw_y;
  assign lane_raw[2] = in_raw_z;

  for (genvar g = 0; g < taff_pkg::AXES; g++) begin : g_lane
    taff_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .raw    (lane_raw[g]),
      .done   (lane_done[g]),
      .result (lane_res[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE: begin
        if (accept) begin
          state_nxt = in_err ? T_OUT : T_BUSY;
        end
      end
      T_BUSY:  if (lane_done[0]) state_nxt = T_OUT;
      T_OUT:   if (out_load) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      mode_r      <= taff_pkg::MODE_PLAIN;
      win_r       <= taff_pkg::WIN_RESET;
      res_r       <= taff_pkg::RES_RESET;
      weight_r    <= taff_pkg::WEIGHT_RESET;
      count_r     <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          taff_pkg::CFG_MODE: begin
            mode_r  <= cfg_wdata[1:0];
            count_r <= '0;
            full_r  <= 1'b0;
          end
          taff_pkg::CFG_WINDOW: win_r <= (cfg_wdata[7:0] == 8'd0) ? 8'd1 : cfg_wdata[7:0];
          taff_pkg::CFG_RES:    res_r <= cfg_wdata;
          taff_pkg::CFG_WEIGHT: weight_r <= cfg_wdata;
          default: ;
        endcase
      end else if (ctl.start) begin
        if (op == taff_pkg::OP_FILL) begin
          count_r <= count_r + 8'd1;
        end else if (op == taff_pkg::OP_CONVERT) begin
          full_r <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= in_status;
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_x_r      <= (status_r == taff_pkg::ST_OK) ? lane_res[0] : '0;
      out_y_r      <= (status_r == taff_pkg::ST_OK) ? lane_res[1] : '0;
      out_z_r      <= (status_r == taff_pkg::ST_OK) ? lane_res[2] : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_field_x = out_x_r;
  assign out_field_y = out_y_r;
  assign out_field_z = out_z_r;

  `TAFF_ASSERT(a_lanes_in_step, (lane_done == 3'b000) || (lane_done == 3'b111), "lanes apart")
  `TAFF_ASSERT(a_done_when_busy, !lane_done[0] || (state_r == T_BUSY), "lane done while not busy")
  `TAFF_ASSERT(a_full_only_avg, !full_r || (mode_r == taff_pkg::MODE_AVG), "stray window full")
  `TAFF_ASSERT(a_count_only_avg, count_r == 8'd0 || mode_r == taff_pkg::MODE_AVG, "stray count")
  `TAFF_ASSERT_NEXT(a_err_skips_lanes, accept && in_err, state_r == T_OUT, "error word in lanes")

endmodule

[sim/three_axis_field_filter_test.sv]
// Self-checking testbench for the three-axis field filter: plain, averaging and smoothing modes,
// error status words, window changes and register extremes, with random idling on both channels.
// Depends on taff_pkg and the three_axis_field_filter RTL only.
module three_axis_field_filter_test;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam longint UNITY_Q16 = 65536;

  typedef struct packed {
    logic              data_ready;
    logic              bus_ok;
    logic              overflow;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic              hold;
  } sample_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [2:0][31:0] field;
  } fields_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_data_ready = 1'b0;
  logic in_bus_ok = 1'b0;
  logic in_overflow = 1'b0;
  logic signed [taff_pkg::RAW_W-1:0] in_raw_x = '0;
  logic signed [taff_pkg::RAW_W-1:0] in_raw_y = '0;
  logic signed [taff_pkg::RAW_W-1:0] in_raw_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic signed [taff_pkg::FIELD_W-1:0] out_field_x;
  logic signed [taff_pkg::FIELD_W-1:0] out_field_y;
  logic signed [taff_pkg::FIELD_W-1:0] out_field_z;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = taff_pkg::CFG_MODE;
  logic [15:0] cfg_wdata = '0;

  logic [1:0]  mode_reg = taff_pkg::MODE_PLAIN;
  logic [7:0]  win_reg = taff_pkg::WIN_RESET;
  logic [15:0] res_reg = taff_pkg::RES_RESET;
  logic [15:0] weight_reg = taff_pkg::WEIGHT_RESET;
  longint      avg_sum [taff_pkg::AXES] = '{default: 0};
  int unsigned avg_count = 0;
  bit          avg_full = 1'b0;
  longint      smooth_val [taff_pkg::AXES] = '{default: 0};

  sample_t raw_samples [$];
  fields_t pending_fields [$];
  sample_t current_sample;
  int samples_queued = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit idle_off = 1'b0;

  three_axis_field_filter u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_ready(in_data_ready),
    .in_bus_ok    (in_bus_ok),
    .in_overflow  (in_overflow),
    .in_raw_x     (in_raw_x),
    .in_raw_y     (in_raw_y),
    .in_raw_z     (in_raw_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_field_x  (out_field_x),
    .out_field_y  (out_field_y),
    .out_field_z  (out_field_z),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Status decode, scaling and the per-mode filter update for one accepted word.
  function automatic fields_t filtered_fields(sample_t s);
    fields_t r;
    logic signed [15:0] raw [taff_pkg::AXES];
    longint scaled;
    longint axis_out;
    longint n;
    longint w;
    bit filling;
    r = '0;
    raw[0] = s.x;
    raw[1] = s.y;
    raw[2] = s.z;
    if (!s.data_ready) r.status = taff_pkg::ST_NO_DATA;
    else if (!s.bus_ok) r.status = taff_pkg::ST_BUS_FAIL;
    else if (s.overflow) r.status = taff_pkg::ST_OVERFLOW;
    else r.status = taff_pkg::ST_OK;
    if (r.status != taff_pkg::ST_OK) return r;
    n = longint'(win_reg);
    w = longint'(weight_reg);
    filling = 1'b0;
    if (mode_reg == taff_pkg::MODE_AVG) begin
      if (!avg_full && avg_count < win_reg) begin
        avg_count++;
        filling = 1'b1;
      end else if (!avg_full) begin
        for (int a = 0; a < taff_pkg::AXES; a++) avg_sum[a] = avg_sum[a] / longint'(avg_count);
        avg_full = 1'b1;
      end
    end
    for (int a = 0; a < taff_pkg::AXES; a++) begin
      scaled = longint'(raw[a]) * longint'(res_reg);
      case (mode_reg)
        taff_pkg::MODE_AVG: begin
          if (filling) begin
            avg_sum[a] += scaled;
            axis_out = avg_sum[a] / longint'(avg_count);
          end else begin
            avg_sum[a] = (avg_sum[a] * (n - 1) + scaled) / n;
            axis_out = avg_sum[a];
          end
        end
        taff_pkg::MODE_EXP: begin
          smooth_val[a] = (w * scaled + (UNITY_Q16 - w) * smooth_val[a]) / UNITY_Q16;
          axis_out = smooth_val[a];
        end
        default: axis_out = scaled;
      endcase
      r.field[a] = axis_out[31:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin : drive_samples
    bit next_valid;
    next_valid = in_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_fields.push_back(filtered_fields(current_sample));
        samples_sent <= samples_sent + 1;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (raw_samples.size() != 0 &&
                     !(raw_samples[0].hold && (in_valid || samples_sent != results_seen))) begin
          current_sample = raw_samples.pop_front();
          in_data_ready <= current_sample.data_ready;
          in_bus_ok <= current_sample.bus_ok;
          in_overflow <= current_sample.overflow;
          in_raw_x <= current_sample.x;
          in_raw_y <= current_sample.y;
          in_raw_z <= current_sample.z;
          next_valid = 1'b1;
          if (!idle_off && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 5);
        end
      end
      in_valid <= next_valid;
    end
  end

  always @(posedge clk) begin : check_results
    fields_t want;
    logic [2:0][31:0] seen;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        seen = {out_field_z, out_field_y, out_field_x};
        if (pending_fields.size() == 0) begin
          report_mismatch($sformatf("unexpected word with status %0d", out_status));
        end else begin
          want = pending_fields.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
          for (int a = 0; a < taff_pkg::AXES; a++) begin
            if (seen[a] !== want.field[a])
              report_mismatch($sformatf("axis %0d field %0d, expected %0d", a,
                                        $signed(seen[a]), $signed(want.field[a])));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_register(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      taff_pkg::CFG_MODE: begin
        mode_reg = val[1:0];
        avg_sum = '{default: 0};
        avg_count = 0;
        avg_full = 1'b0;
      end
      taff_pkg::CFG_WINDOW: win_reg = (val[7:0] == 8'd0) ? 8'd1 : val[7:0];
      taff_pkg::CFG_RES: res_reg = val;
      taff_pkg::CFG_WEIGHT: weight_reg = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (samples_queued != samples_sent || samples_sent != results_seen) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic queue_sample(logic dr, logic ok, logic ovf, logic signed [15:0] x,
                              logic signed [15:0] y, logic signed [15:0] z, logic hold);
    raw_samples.push_back('{dr, ok, ovf, x, y, z, hold});
    samples_queued++;
  endtask

  function automatic logic signed [15:0] random_axis(bit bias);
    logic [31:0] r;
    int pick;
    pick = $urandom_range(0, 9);
    r = $urandom;
    if (pick < (bias ? 6 : 2)) return r[0] ? 16'sh7fff : 16'sh8000;
    return r[15:0];
  endfunction

  task automatic queue_random(int count, bit bias, bit all_ok);
    logic [2:0] flags;
    for (int i = 0; i < count; i++) begin
      flags = 3'b110;
      if (!all_ok && $urandom_range(0, 9) >= 8) flags = 3'($urandom_range(0, 7));
      queue_sample(flags[2], flags[1], flags[0], random_axis(bias), random_axis(bias),
                   random_axis(bias), $urandom_range(0, 39) == 0);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_sample(1'b1, 1'b1, 1'b0, 16'sh7fff, 16'sh8000, 16'sh0000, 1'b0);
    queue_sample(1'b1, 1'b1, 1'b0, -16'sd1, 16'sd1, 16'sh0000, 1'b0);
    queue_sample(1'b0, 1'b1, 1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    queue_sample(1'b0, 1'b0, 1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    queue_sample(1'b1, 1'b0, 1'b1, 16'sh1234, -16'sd5, 16'sh0001, 1'b0);
    queue_sample(1'b1, 1'b0, 1'b0, -16'sd1, -16'sd1, -16'sd1, 1'b0);
    queue_sample(1'b1, 1'b1, 1'b1, 16'sh5555, 16'sh2aaa, -16'sd2, 1'b0);
    queue_sample(1'b0, 1'b0, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
    queue_random(30, 1'b0, 1'b0);
    wait_drained();

    write_register(taff_pkg::CFG_RES, 16'hffff);
    queue_sample(1'b1, 1'b1, 1'b0, 16'sh8000, 16'sh7fff, -16'sd1, 1'b0);
    queue_sample(1'b1, 1'b1, 1'b0, 16'sh7fff, 16'sh8000, 16'sd1, 1'b0);
    queue_random(10, 1'b1, 1'b0);
    wait_drained();

    write_register(taff_pkg::CFG_RES, 16'h0000);
    queue_sample(1'b1, 1'b1, 1'b0, 16'sh7fff, 16'sh8000, -16'sd1, 1'b0);
    queue_random(5, 1'b0, 1'b0);
    wait_drained();

    write_register(taff_pkg::CFG_RES, 16'd12345);
    write_register(taff_pkg::CFG_MODE, 16'(MODE_SPARE));
    queue_random(20, 1'b0, 1'b0);
    wait_drained();

    write_register(taff_pkg::CFG_WINDOW, 16'h0000);
    write_register(taff_pkg::CFG_RES, 16'hffff);
    write_register(taff_pkg::CFG_MODE, 16'(taff_pkg::MODE_AVG));
    queue_sample(1'b1, 1'b1, 1'b0, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0);
    queue_sample(1'b1, 1'b1, 1'b0, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
    queue_random(15, 1'b1, 1'b0);
    wait_drained();

    write_register(taff_pkg::CFG_WINDOW, 16'd4);
    write_register(taff_pkg::CFG_MODE, 16'(taff_pkg::MODE_AVG));
    queue_random(20, 1'b0, 1'b0);
    queue_sample(1'b1, 1'b1, 1'b0, 16'sh4000, -16'sd300, 16'sh7fff, 1'b1);
    queue_random(19, 1'b0, 1'b0);
    wait_drained();

    // Shrink the window below the partial count, then widen it after the mean is formed.
    write_register(taff_pkg::CFG_WINDOW, 16'd8);
    write_register(taff_pkg::CFG_MODE, 16'(taff_pkg::MODE_AVG));
    queue_random(5, 1'b0, 1'b1);
    wait_drained();
    write_register(taff_pkg::CFG_WINDOW, 16'd3);
    queue_random(6, 1'b0, 1'b1);
    wait_drained();
    write_register(taff_pkg::CFG_WINDOW, 16'd6);
    queue_random(10, 1'b0, 1'b0);
    wait_drained();

    write_register(taff_pkg::CFG_WINDOW, 16'd255);
    write_register(taff_pkg::CFG_MODE, 16'(taff_pkg::MODE_AVG));
    queue_random(250, 1'b1, 1'b1);
    queue_random(15, 1'b1, 1'b0);
    wait_drained();

    write_register(taff_pkg::CFG_WEIGHT, 16'h0000);
    write_register(taff_pkg::CFG_RES, taff_pkg::RES_RESET);
    write_register(taff_pkg::CFG_MODE, 16'(taff_pkg::MODE_EXP));
    queue_random(15, 1'b0, 1'b0);
    wait_drained();

    write_register(taff_pkg::CFG_WEIGHT, 16'hffff);
    write_register(taff_pkg::CFG_RES, 16'hffff);
    queue_random(15, 1'b1, 1'b0);
    wait_drained();

    write_register(taff_pkg::CFG_MODE, 16'(taff_pkg::MODE_PLAIN));
    queue_random(5, 1'b0, 1'b0);
    wait_drained();

    write_register(taff_pkg::CFG_WEIGHT, taff_pkg::WEIGHT_RESET);
    write_register(taff_pkg::CFG_MODE, 16'(taff_pkg::MODE_EXP));
    idle_off <= 1'b1;
    queue_random(30, 1'b0, 1'b0);
    wait_drained();

    if (pending_fields.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", pending_fields.size()));
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
